// ===== rtl/picaw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picaw_pkg
// Shared widths, register indexes and controller-to-datapath command types
// for the Q15 PI controller.
// ----------------------------------------------------------------------------
package picaw_pkg;

    localparam int DATA_W    = 16;   // Q15 sample and gain width
    localparam int ACC_W     = 32;   // integral and product width
    localparam int Q_SHIFT   = 15;   // Q15 rescale of the sum
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER   = 3'd4;

    localparam logic signed [DATA_W-1:0] OUT_UPPER_RST = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_LOWER_RST = 16'sh8000;

    // Operand pair routed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_P,   // prop_gain   * error (error taken from the input ports)
        MUL_I,   // integ_gain  * stored error
        MUL_C    // windup_gain * clamp excess
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;    // input beat accepted: store error
        logic     prod_en;    // capture multiplier result
        t_mul_sel mul_sel;
        logic     clamp_en;   // form raw sum, clamp, store drive and excess
        logic     integ_add;  // integral += integ_gain * error
        logic     integ_sub;  // integral -= windup_gain * excess, load output
    } t_dp_cmd;

endpackage

// ===== rtl/picaw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picaw_ctrl
// Sequencer: steps one item through the shared multiplier and owns the
// input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module picaw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output picaw_pkg::t_dp_cmd o_cmd
);
    import picaw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLAMP,
        S_INTEG,
        S_WIND
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '{load_in: 1'b0, prod_en: 1'b0, mul_sel: MUL_P,
                        clamp_en: 1'b0, integ_add: 1'b0, integ_sub: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_cmd.mul_sel = MUL_P;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.prod_en = 1'b1;
                    n_state       = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.clamp_en = 1'b1;
                o_cmd.mul_sel  = MUL_I;
                o_cmd.prod_en  = 1'b1;
                n_state        = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.integ_add = 1'b1;
                o_cmd.mul_sel   = MUL_C;
                o_cmd.prod_en   = 1'b1;
                n_state         = S_WIND;
            end
            S_WIND: begin
                o_cmd.mul_sel = MUL_C;
                // hold here until the output register can take the new beat
                if (w_slot_free) begin
                    o_cmd.integ_sub = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/picaw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picaw_dp
// Datapath: configuration registers, one shared 16x16 multiplier, clamp,
// integral accumulator and output register.
// ----------------------------------------------------------------------------
module picaw_dp (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [picaw_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [picaw_pkg::DATA_W-1:0]             i_cfg_data,
    input  logic signed [picaw_pkg::DATA_W-1:0]      i_setpoint,
    input  logic signed [picaw_pkg::DATA_W-1:0]      i_measured,
    input  picaw_pkg::t_dp_cmd                       i_cmd,
    output logic signed [picaw_pkg::DATA_W-1:0]      o_drive
);
    import picaw_pkg::*;

    logic signed [DATA_W-1:0] r_prop_gain, r_integ_gain, r_windup_gain;
    logic signed [DATA_W-1:0] r_out_upper, r_out_lower;
    logic signed [ACC_W-1:0]  r_integ;
    logic signed [ACC_W-1:0]  r_prod;
    logic signed [DATA_W-1:0] r_err, r_excess, r_drive, r_drive_out;

    logic signed [DATA_W-1:0] w_err_in;
    logic signed [DATA_W-1:0] w_mul_a, w_mul_b;
    logic signed [ACC_W-1:0]  w_mul_p;
    logic [ACC_W-1:0]         w_sum;
    logic signed [DATA_W-1:0] w_raw, w_clamped;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_windup_gain <= '0;
            r_out_upper   <= OUT_UPPER_RST;
            r_out_lower   <= OUT_LOWER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                CFG_WINDUP_GAIN: r_windup_gain <= i_cfg_data;
                CFG_OUT_UPPER:   r_out_upper   <= i_cfg_data;
                CFG_OUT_LOWER:   r_out_lower   <= i_cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    assign w_err_in = i_setpoint - i_measured;   // 16-bit wrap

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_P: begin
                w_mul_a = r_prop_gain;
                w_mul_b = w_err_in;
            end
            MUL_I: begin
                w_mul_a = r_integ_gain;
                w_mul_b = r_err;
            end
            MUL_C: begin
                w_mul_a = r_windup_gain;
                w_mul_b = r_excess;
            end
            default: begin
                w_mul_a = r_prop_gain;
                w_mul_b = w_err_in;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // raw output and clamp, upper test first
    assign w_sum = r_prod + r_integ;
    assign w_raw = w_sum[Q_SHIFT +: DATA_W];

    always_comb begin
        priority if (w_raw > r_out_upper) w_clamped = r_out_upper;
        else if (w_raw < r_out_lower)     w_clamped = r_out_lower;
        else                              w_clamped = w_raw;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in)  r_err <= w_err_in;
        if (i_cmd.prod_en)  r_prod <= w_mul_p;
        if (i_cmd.clamp_en) begin
            r_drive  <= w_clamped;
            r_excess <= w_raw - w_clamped;
        end
        if (i_cmd.integ_sub) r_drive_out <= r_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.integ_add) begin
            r_integ <= r_integ + r_prod;
        end else if (i_cmd.integ_sub) begin
            r_integ <= r_integ - r_prod;
        end
    end

    assign o_drive = r_drive_out;

endmodule

// ===== rtl/pi_controller_antiwindup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_controller_antiwindup
// Q15 PI controller with clamped output and back-calculation anti-windup.
// ----------------------------------------------------------------------------
// One input beat (setpoint, measured) gives one drive beat. The three
// products (Kp*e, Ki*e, Kc*excess) share a single 16x16 multiplier and
// issue one per cycle in the accept, clamp and integrate steps; the result
// is loaded in the wind-back step, and only then is a new item accepted.
// The finished drive sits in an output register; the next item is accepted
// while it waits, and the sequencer only holds in its last step if a second
// result is ready before the first was taken. Reset clears the integral and
// loads the gains to zero and the limits to full scale. Configuration writes
// take effect at once and belong in idle periods only.
// ----------------------------------------------------------------------------
module pi_controller_antiwindup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [picaw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [picaw_pkg::DATA_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [picaw_pkg::DATA_W-1:0]   i_setpoint,
    input  logic signed [picaw_pkg::DATA_W-1:0]   i_measured,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [picaw_pkg::DATA_W-1:0]   o_drive
);
    import picaw_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer: accept, clamp, integrate, wind-back
    picaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // arithmetic, configuration and integral state
    picaw_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .i_cmd      (w_cmd),
        .o_drive    (o_drive)
    );

endmodule

// ===== rtl/picaw_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// picaw_chk
// Port-level checks on handshake timing of the PI controller.
// ----------------------------------------------------------------------------
module picaw_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic signed [picaw_pkg::DATA_W-1:0] o_drive
);
    import picaw_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_drive)))
        else $error("output beat dropped or changed while stalled");

    // accepted item keeps the input closed for its three work steps
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready ##1 !o_in_ready ##1 !o_in_ready))
        else $error("input reopened before item finished");

    // a new result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result issued outside final step");

    // reset empties the output and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("reset did not clear handshake state");

endmodule

bind pi_controller_antiwindup picaw_chk u_picaw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_drive     (o_drive)
);
